// ===== hdl/zsr_pkg.sv =====
// zsr_pkg: shared types, codes and crc helper for the subpacket receiver
// no dependencies; imported by every module of the block
`default_nettype none

package zsr_pkg;

   localparam logic [7:0] ESC_CHAR    = 8'h18;
   localparam logic [7:0] XON_CHAR    = 8'h11;
   localparam logic [7:0] XON_HI      = 8'h91;
   localparam logic [7:0] XOFF_CHAR   = 8'h13;
   localparam logic [7:0] XOFF_HI     = 8'h93;
   localparam logic [7:0] CLASS_MASK  = 8'h60;
   localparam logic [7:0] CLASS_PRINT = 8'h40;
   localparam logic [7:0] END_CRCE    = 8'h68;
   localparam logic [7:0] END_CRCG    = 8'h69;
   localparam logic [7:0] END_CRCQ    = 8'h6a;
   localparam logic [7:0] END_CRCW    = 8'h6b;
   localparam logic [7:0] ESC_RUB     = 8'h6c;
   localparam logic [7:0] ESC_RUB_HI  = 8'h6d;
   localparam logic [7:0] RUB_VALUE   = 8'h7f;
   localparam logic [7:0] RUB_HI_VAL  = 8'hff;

   localparam logic [31:0] CRC32_INIT = 32'hffff_ffff;
   localparam logic [31:0] CRC32_POLY = 32'hedb8_8320;
   localparam logic [15:0] CRC16_POLY = 16'h1021;
   localparam logic [31:0] COUNT_MAX  = 32'hffff_ffff;

   localparam logic [2:0] TRAILER_LEN16 = 3'd2;
   localparam logic [2:0] TRAILER_LEN32 = 3'd4;

   // register indexes of the configuration port
   localparam logic CSR_USE_CRC32       = 1'b0;
   localparam logic CSR_ESCAPE_CONTROLS = 1'b1;

   typedef enum logic [1:0] {
      KIND_PAYLOAD  = 2'd0,
      KIND_BAD      = 2'd1,
      KIND_CONTINUE = 2'd2,
      KIND_END      = 2'd3
   } zsr_kind_type;

   typedef enum logic [1:0] {
      DEC_NONE = 2'd0,
      DEC_DATA = 2'd1,
      DEC_END  = 2'd2
   } zsr_dec_kind_type;

   typedef struct packed {
      zsr_dec_kind_type kind;
      logic [7:0]       value;
      logic             escape_next;
   } zsr_decode_type;

   typedef struct packed {
      logic use_crc32;
      logic escape_controls;
   } zsr_cfg_type;

   typedef struct packed {
      logic valid;
      logic crc32;
   } zsr_restart_type;

   typedef struct packed {
      logic         valid;
      zsr_kind_type kind;
      logic [7:0]   payload_byte;
      logic         ack_request;
      logic [31:0]  ack_position;
      logic [31:0]  payload_count;
   } zsr_result_type;

   // byte-wide crc update, crc-32 reflected or crc-16 msb first
   function automatic logic [31:0] crc_update(input logic [31:0] crc,
                                               input logic [7:0] b,
                                               input logic crc32);
      logic [31:0] c32;
      logic [15:0] c16;
      c32 = crc ^ {24'd0, b};
      c16 = crc[15:0] ^ {b, 8'd0};
      for (int i = 0; i < 8; i++) begin
         c32 = c32[0] ? ((c32 >> 1) ^ CRC32_POLY) : (c32 >> 1);
         c16 = c16[15] ? ((c16 << 1) ^ CRC16_POLY) : (c16 << 1);
      end
      return crc32 ? c32 : {16'd0, c16};
   endfunction

endpackage

`default_nettype wire

// ===== hdl/zsr_req_if.sv =====
// zsr_req_if: input channel of the subpacket receiver, valid/ready plus item
// depends on nothing
`default_nettype none

interface zsr_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [7:0]  line_byte;
   logic [31:0] load_position;

   modport source (output valid, output op, output line_byte, output load_position,
                   input ready);
   modport sink   (input valid, input op, input line_byte, input load_position,
                   output ready);
endinterface

`default_nettype wire

// ===== hdl/zsr_rsp_if.sv =====
// zsr_rsp_if: result channel of the subpacket receiver, valid/ready plus result
// depends on nothing
`default_nettype none

interface zsr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  payload_byte;
   logic        ack_request;
   logic [31:0] ack_position;
   logic [31:0] payload_count;

   modport source (output valid, output kind, output payload_byte, output ack_request,
                   output ack_position, output payload_count, input ready);
   modport sink   (input valid, input kind, input payload_byte, input ack_request,
                   input ack_position, input payload_count, output ready);
endinterface

`default_nettype wire

// ===== hdl/zsr_decoder.sv =====
// zsr_decoder: combinational escape decoder for one line byte
// depends on zsr_pkg
`default_nettype none

module zsr_decoder
   import zsr_pkg::*;
(
   input  wire logic           escape_pending,
   input  wire logic           escape_controls,
   input  wire logic [7:0]     line_byte,
   output zsr_decode_type      decode
);

   logic is_flow;
   logic is_ctrl;

   assign is_flow = (line_byte == XON_CHAR) || (line_byte == XON_HI) ||
                    (line_byte == XOFF_CHAR) || (line_byte == XOFF_HI);
   assign is_ctrl = escape_controls && ((line_byte & CLASS_MASK) == 8'h00);

   always_comb begin
      decode.kind        = DEC_NONE;
      decode.value       = line_byte;
      decode.escape_next = escape_pending;
      if (!escape_pending) begin
         if (line_byte == ESC_CHAR) begin
            decode.escape_next = 1'b1;
         end else if (!is_flow && !is_ctrl) begin
            decode.kind = DEC_DATA;
         end
      end else if (!is_flow && (line_byte != ESC_CHAR)) begin
         if ((line_byte >= END_CRCE) && (line_byte <= END_CRCW)) begin
            decode.kind        = DEC_END;
            decode.escape_next = 1'b0;
         end else if (line_byte == ESC_RUB) begin
            decode.kind        = DEC_DATA;
            decode.value       = RUB_VALUE;
            decode.escape_next = 1'b0;
         end else if (line_byte == ESC_RUB_HI) begin
            decode.kind        = DEC_DATA;
            decode.value       = RUB_HI_VAL;
            decode.escape_next = 1'b0;
         end else if (!is_ctrl) begin
            // escape is consumed; only the 0x40 class decodes to data
            decode.escape_next = 1'b0;
            if ((line_byte & CLASS_MASK) == CLASS_PRINT) begin
               decode.kind  = DEC_DATA;
               decode.value = line_byte ^ CLASS_PRINT;
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/zsr_framer.sv =====
// zsr_framer: subpacket state, crc, trailer check and file position
// depends on zsr_pkg and zsr_decoder
`default_nettype none

module zsr_framer
   import zsr_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            step,
   input  wire logic            op,
   input  wire logic [7:0]      line_byte,
   input  wire logic [31:0]     load_position,
   input  wire zsr_cfg_type     cfg,
   input  wire zsr_restart_type restart,
   output zsr_result_type       result
);

   logic        escape_pending_ff, escape_pending_in;
   logic        in_trailer_ff, in_trailer_in;
   logic [2:0]  trailer_index_ff, trailer_index_in;
   logic [31:0] crc_accum_ff, crc_accum_in;
   logic [31:0] received_crc_ff, received_crc_in;
   logic [7:0]  frame_type_ff, frame_type_in;
   logic [31:0] byte_count_ff, byte_count_in;
   logic [31:0] file_position_ff, file_position_in;

   zsr_decode_type decode;
   logic [31:0]    crc_next;
   logic [31:0]    count_next;
   logic [31:0]    rx_crc_next;
   logic [2:0]     index_next;
   logic [31:0]    expect_crc;
   logic           good;
   logic           clear;
   logic           clear_crc32;

   zsr_decoder u_decoder (
      .escape_pending  (escape_pending_ff),
      .escape_controls (cfg.escape_controls),
      .line_byte       (line_byte),
      .decode          (decode)
   );

   assign crc_next   = crc_update(crc_accum_ff, decode.value, cfg.use_crc32);
   assign count_next = (byte_count_ff == COUNT_MAX) ? byte_count_ff : byte_count_ff + 32'd1;
   assign index_next = trailer_index_ff + 3'd1;
   assign expect_crc = cfg.use_crc32 ? ~crc_accum_ff : {16'd0, crc_accum_ff[15:0]};
   assign good       = (rx_crc_next == expect_crc) && (byte_count_ff <= ~file_position_ff);

   always_comb begin
      if (cfg.use_crc32) begin
         case (trailer_index_ff[1:0])
            2'd0:    rx_crc_next = received_crc_ff | {24'd0, decode.value};
            2'd1:    rx_crc_next = received_crc_ff | {16'd0, decode.value, 8'd0};
            2'd2:    rx_crc_next = received_crc_ff | {8'd0, decode.value, 16'd0};
            default: rx_crc_next = received_crc_ff | {decode.value, 24'd0};
         endcase
      end else begin
         rx_crc_next = {16'd0, received_crc_ff[7:0], decode.value};
      end
   end

   always_comb begin
      escape_pending_in = escape_pending_ff;
      in_trailer_in     = in_trailer_ff;
      trailer_index_in  = trailer_index_ff;
      crc_accum_in      = crc_accum_ff;
      received_crc_in   = received_crc_ff;
      frame_type_in     = frame_type_ff;
      byte_count_in     = byte_count_ff;
      file_position_in  = file_position_ff;
      clear             = 1'b0;
      clear_crc32       = cfg.use_crc32;

      result.valid         = 1'b0;
      result.kind          = KIND_PAYLOAD;
      result.payload_byte  = 8'd0;
      result.ack_request   = 1'b0;
      result.ack_position  = file_position_ff;
      result.payload_count = byte_count_ff;

      if (restart.valid) begin
         clear       = 1'b1;
         clear_crc32 = restart.crc32;
      end else if (step && op) begin
         file_position_in = load_position;
         clear            = 1'b1;
      end else if (step) begin
         escape_pending_in = decode.escape_next;
         if (decode.kind == DEC_DATA && !in_trailer_ff) begin
            crc_accum_in         = crc_next;
            byte_count_in        = count_next;
            result.valid         = 1'b1;
            result.payload_byte  = decode.value;
            result.payload_count = count_next;
         end else if (decode.kind == DEC_END && !in_trailer_ff) begin
            frame_type_in    = decode.value;
            crc_accum_in     = crc_next;
            in_trailer_in    = 1'b1;
            trailer_index_in = 3'd0;
            received_crc_in  = 32'd0;
         end else if (decode.kind == DEC_END) begin
            // end marker inside the trailer kills the subpacket
            result.valid = 1'b1;
            result.kind  = KIND_BAD;
            clear        = 1'b1;
         end else if (decode.kind == DEC_DATA) begin
            received_crc_in  = rx_crc_next;
            trailer_index_in = index_next;
            if (index_next >= (cfg.use_crc32 ? TRAILER_LEN32 : TRAILER_LEN16)) begin
               result.valid = 1'b1;
               clear        = 1'b1;
               if (!good) begin
                  result.kind = KIND_BAD;
               end else begin
                  result.kind = ((frame_type_ff == END_CRCG) || (frame_type_ff == END_CRCQ))
                                ? KIND_CONTINUE : KIND_END;
                  result.ack_request = (frame_type_ff == END_CRCQ) ||
                                       (frame_type_ff == END_CRCW);
                  file_position_in   = file_position_ff + byte_count_ff;
               end
            end
         end
      end

      if (clear) begin
         escape_pending_in = 1'b0;
         in_trailer_in     = 1'b0;
         trailer_index_in  = 3'd0;
         crc_accum_in      = clear_crc32 ? CRC32_INIT : 32'd0;
         received_crc_in   = 32'd0;
         frame_type_in     = 8'd0;
         byte_count_in     = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_pending_ff <= 1'b0;
         in_trailer_ff     <= 1'b0;
         trailer_index_ff  <= 3'd0;
         crc_accum_ff      <= 32'd0;
         received_crc_ff   <= 32'd0;
         frame_type_ff     <= 8'd0;
         byte_count_ff     <= 32'd0;
         file_position_ff  <= 32'd0;
      end else begin
         escape_pending_ff <= escape_pending_in;
         in_trailer_ff     <= in_trailer_in;
         trailer_index_ff  <= trailer_index_in;
         crc_accum_ff      <= crc_accum_in;
         received_crc_ff   <= received_crc_in;
         frame_type_ff     <= frame_type_in;
         byte_count_ff     <= byte_count_in;
         file_position_ff  <= file_position_in;
      end
   end

   trailer_index_bound: assert property (@(posedge clock) disable iff (reset)
      trailer_index_ff <= TRAILER_LEN32)
      else $error("trailer index ran past the crc trailer");

   trailer_only_after_marker: assert property (@(posedge clock) disable iff (reset)
      !in_trailer_ff |-> (trailer_index_ff == 3'd0) && (received_crc_ff == 32'd0))
      else $error("trailer state set outside a trailer");

   load_clears_count: assert property (@(posedge clock) disable iff (reset)
      step && op && !restart.valid |=> byte_count_ff == 32'd0 && !in_trailer_ff)
      else $error("position load did not restart the subpacket");

endmodule

`default_nettype wire

// ===== hdl/zmodem_subpacket_receiver_unit.sv =====
// zmodem_subpacket_receiver_unit: top level, handshake, csr registers, result register
// depends on zsr_pkg, zsr_req_if, zsr_rsp_if and zsr_framer
`default_nettype none

// channel  | dir | payload                                              | transaction
// ---------+-----+------------------------------------------------------+-------------------
// req_ch   | in  | op, line_byte, load_position                         | valid & ready
// rsp_ch   | out | kind, payload_byte, ack_request, ack_position, count | valid & ready
// csr      | in  | csr_index (0 use_crc32, 1 escape_controls), data     | csr_write_enable
//
// one transaction per cycle if not stalled: each line byte is decoded, crc-updated and
// checked in its accept cycle; the byte-wide crc xor network sets the path length
// a result lands in a one-deep output register; req_ch.ready stays high while that
// register is empty or being drained, so a stall on rsp_ch backs up req_ch directly
// reset (synchronous, active high) clears state: crc-16 mode, no control escaping,
// file position 0, no result pending
// a write to use_crc32 restarts the subpacket in progress

module zmodem_subpacket_receiver_unit
   import zsr_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   zsr_req_if.sink    req_ch,
   zsr_rsp_if.source  rsp_ch,
   input  wire logic  csr_write_enable,
   input  wire logic  csr_index,
   input  wire logic  csr_write_data
);

   zsr_cfg_type     cfg_ff, cfg_in;
   zsr_restart_type restart;
   zsr_result_type  result;

   logic         rsp_valid_ff, rsp_valid_in;
   zsr_kind_type kind_ff;
   logic [7:0]   payload_byte_ff;
   logic         ack_request_ff;
   logic [31:0]  ack_position_ff;
   logic [31:0]  payload_count_ff;
   logic         req_accept;
   logic         load_result;

   // csr decode
   always_comb begin
      cfg_in        = cfg_ff;
      restart.valid = 1'b0;
      restart.crc32 = csr_write_data;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_USE_CRC32: begin
               cfg_in.use_crc32 = csr_write_data;
               restart.valid    = 1'b1;
            end
            CSR_ESCAPE_CONTROLS: begin
               cfg_in.escape_controls = csr_write_data;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input side free whenever the result register can take a new value
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_accept   = req_ch.valid && req_ch.ready;

   zsr_framer u_framer (
      .clock         (clock),
      .reset         (reset),
      .step          (req_accept),
      .op            (req_ch.op),
      .line_byte     (req_ch.line_byte),
      .load_position (req_ch.load_position),
      .cfg           (cfg_ff),
      .restart       (restart),
      .result        (result)
   );

   assign load_result = req_accept && result.valid;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (load_result) begin
         kind_ff          <= result.kind;
         payload_byte_ff  <= result.payload_byte;
         ack_request_ff   <= result.ack_request;
         ack_position_ff  <= result.ack_position;
         payload_count_ff <= result.payload_count;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.kind          = kind_ff;
   assign rsp_ch.payload_byte  = payload_byte_ff;
   assign rsp_ch.ack_request   = ack_request_ff;
   assign rsp_ch.ack_position  = ack_position_ff;
   assign rsp_ch.payload_count = payload_count_ff;

   stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ch.ready |-> !req_ch.ready)
      else $error("input accepted while the result register is stalled");

   result_needs_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_accept))
      else $error("result appeared without an accepted transaction");

   load_gives_no_result: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_ch.op |=> !$rose(rsp_valid_ff))
      else $error("position load produced a result");

   ack_only_on_good: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && ack_request_ff |->
         (kind_ff == KIND_CONTINUE || kind_ff == KIND_END) && payload_byte_ff == 8'd0)
      else $error("ack flag on a payload or bad result");

endmodule

`default_nettype wire
